// File: rtl/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
// No dependencies; imported by every module of the block.
package pba_pkg;

	localparam int PAGE_W  = 16;   // page number width
	localparam int COUNT_W = 17;   // page count / free count width
	localparam int WORD_W  = 32;   // bitmap word width, pages per word
	localparam int BIT_W   = 5;    // bit position within a word
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int MAX_PAGES = 65536;

	localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MARK_USED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MARK_FREE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_PAGE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	// outcome of searching one bitmap word for a free page
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_pos;
	} scan_hit_t;

endpackage

// File: rtl/pba_bitmap_ram.sv
// Bitmap store: one write port, one read port, registered read data.
// Depends on pba_pkg for the word width.
module pba_bitmap_ram
	import pba_pkg::*;
#(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/pba_word_scan.sv
// Finds the lowest free page in one bitmap word, honouring the range bounds.
// Depends on pba_pkg for widths and the scan_hit_t result type.
module pba_word_scan
	import pba_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	input  logic              is_first,   // word holds page 0, never handed out
	input  logic              is_last,    // word holds the top of the range
	input  logic [BIT_W-1:0]  lim_low,    // limit mod 32, zero means full word
	output scan_hit_t         hit
);

	logic [WORD_W-1:0] cand;

	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			cand[j] = ~word[j]
				& ~(is_first && (j == 0))
				& ~(is_last && (lim_low != '0) && (BIT_W'(j) >= lim_low));
		end
	end

	always_comb begin
		hit.found   = |cand;
		hit.bit_pos = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (cand[j]) begin
				hit.bit_pos = BIT_W'(j);
			end
		end
	end

endmodule

// File: rtl/page_bitmap_allocator.sv
// Page bitmap allocator top level: request FSM, scan pointer, used counter.
// Depends on pba_pkg, pba_bitmap_ram and pba_word_scan.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | tuser: mode; tdata: page_index
//  m_*     | out | m_tvalid / m_tready  | tuser: status; tdata: result_page, free_count
//  cfg_*   | in  | cfg_valid/cfg_ready  | cfg_data: page_count
//
// After reset a clearing pass zeroes the bitmap, one word a cycle, during which no
// request is taken (page_count writes still are).
// Mark requests read the word, modify and write it, then give the result, plus any
// wait for the output slot.
// Allocate reads one bitmap word per cycle through the RAM read port until a word
// with a free page is found or the last word of the range has been read.
// One request is in flight at a time; the next is taken while a finished
// transfer still waits on m_tready, and a stalled output holds the FSM in DONE.
module page_bitmap_allocator
	import pba_pkg::*;
#(
	parameter int BITMAP_WORDS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// request: tuser = mode[1:0]; tdata = page_index[15:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,
	input  logic [15:0] s_tdata,
	// result: tuser = status[1:0]; tdata = result_page[15:0], free_count[32:16],
	// [39:33] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,
	output logic [39:0] m_tdata,
	// page_count register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);

	localparam int ADDR_W  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int CAP     = BITMAP_WORDS * WORD_W;
	localparam logic [COUNT_W-1:0] LIM_CAP =
		(CAP < MAX_PAGES) ? COUNT_W'(CAP) : COUNT_W'(MAX_PAGES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_WORDS - 1);

	state_t state_q, state_d;

	logic [COUNT_W-1:0] page_count_q;
	logic [COUNT_W-1:0] used_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic               chk_vld_s1;
	logic [ADDR_W-1:0]  chk_word_s1;
	logic [MODE_W-1:0]  mode_q;
	logic [PAGE_W-1:0]  idx_q;
	logic [PAGE_W-1:0]  res_page_q;
	logic [STAT_W-1:0]  res_stat_q;

	logic               out_vld_q;
	logic [PAGE_W-1:0]  out_page_q;
	logic [STAT_W-1:0]  out_stat_q;
	logic [COUNT_W-1:0] out_free_q;

	// usable pages: smallest of page_count, bitmap capacity and 64Ki
	logic [COUNT_W-1:0] lim;
	logic [COUNT_W-1:0] lim_m1;
	logic [COUNT_W-1:0] last_word;
	logic [COUNT_W-1:0] free_now;

	assign lim       = (page_count_q > LIM_CAP) ? LIM_CAP : page_count_q;
	assign lim_m1    = lim - COUNT_W'(1);
	assign last_word = lim_m1 >> BIT_W;
	assign free_now  = (used_q < lim) ? (lim - used_q) : '0;

	// request fields
	logic               s_xfer;
	logic [MODE_W-1:0]  in_mode;
	logic [PAGE_W-1:0]  in_idx;
	logic [COUNT_W-1:0] in_widx;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign in_mode  = s_tuser;
	assign in_idx   = s_tdata[PAGE_W-1:0];
	assign in_widx  = COUNT_W'(in_idx >> BIT_W);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			page_count_q <= cfg_data;
		end
	end

	// memory ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	pba_bitmap_ram #(
		.DEPTH  (BITMAP_WORDS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// word search for allocate
	scan_hit_t hit;
	logic      chk_last;

	assign chk_last = (COUNT_W'(chk_word_s1) == last_word);

	pba_word_scan u_scan (
		.word     (ram_rdata),
		.is_first (chk_word_s1 == '0),
		.is_last  (chk_last),
		.lim_low  (lim[BIT_W-1:0]),
		.hit      (hit)
	);

	logic [COUNT_W-1:0] hit_page;
	assign hit_page = (COUNT_W'(chk_word_s1) << BIT_W) | COUNT_W'(hit.bit_pos);

	// mark modify
	logic [WORD_W-1:0] bit_mask;
	logic              bit_now;
	assign bit_mask = WORD_W'(1) << idx_q[BIT_W-1:0];
	assign bit_now  = |(ram_rdata & bit_mask);

	logic               issue;
	logic               out_slot;
	logic               used_inc;
	logic               used_dec;
	logic               set_res;
	logic [PAGE_W-1:0]  res_page_d;
	logic [STAT_W-1:0]  res_stat_d;

	assign issue    = (COUNT_W'(ptr_q) <= last_word);
	assign out_slot = !out_vld_q || m_tready;

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = clr_q;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = ptr_q;
		used_inc   = 1'b0;
		used_dec   = 1'b0;
		set_res    = 1'b0;
		res_page_d = '0;
		res_stat_d = STAT_OK;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_xfer) begin
					set_res = 1'b1;
					priority if (in_mode == MODE_ALLOC) begin
						if (lim < COUNT_W'(2)) begin
							res_stat_d = STAT_NO_FREE;
							state_d    = ST_DONE;
						end else begin
							state_d = ST_SCAN;
						end
					end else if (in_mode == MODE_MARK_USED || in_mode == MODE_MARK_FREE) begin
						if (COUNT_W'(in_idx) >= lim) begin
							res_stat_d = STAT_BAD_PAGE;
							state_d    = ST_DONE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = in_widx[ADDR_W-1:0];
							state_d   = ST_MARK;
						end
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				ram_re = issue;
				if (chk_vld_s1) begin
					if (hit.found) begin
						ram_we     = 1'b1;
						ram_waddr  = chk_word_s1;
						ram_wdata  = ram_rdata | (WORD_W'(1) << hit.bit_pos);
						used_inc   = 1'b1;
						set_res    = 1'b1;
						res_page_d = hit_page[PAGE_W-1:0];
						state_d    = ST_DONE;
					end else if (chk_last) begin
						set_res    = 1'b1;
						res_stat_d = STAT_NO_FREE;
						state_d    = ST_DONE;
					end
				end
			end
			ST_MARK: begin
				ram_waddr = ADDR_W'(idx_q >> BIT_W);
				if (mode_q == MODE_MARK_USED) begin
					ram_wdata = ram_rdata | bit_mask;
					ram_we    = !bit_now;
					used_inc  = !bit_now;
				end else begin
					ram_wdata = ram_rdata & ~bit_mask;
					ram_we    = bit_now;
					used_dec  = bit_now;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_slot) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			ptr_q      <= '0;
			chk_vld_s1 <= 1'b0;
			used_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == ST_SCAN) begin
				ptr_q      <= ptr_q + ADDR_W'(1);
				chk_vld_s1 <= issue;
			end else begin
				ptr_q      <= '0;
				chk_vld_s1 <= 1'b0;
			end
			if (used_inc) begin
				used_q <= used_q + COUNT_W'(1);
			end else if (used_dec) begin
				used_q <= used_q - COUNT_W'(1);
			end
			if (state_q == ST_DONE && out_slot) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		chk_word_s1 <= ptr_q;
		if (s_xfer) begin
			mode_q <= in_mode;
			idx_q  <= in_idx;
		end
		if (set_res) begin
			res_page_q <= res_page_d;
			res_stat_q <= res_stat_d;
		end
		if (state_q == ST_DONE && out_slot) begin
			out_page_q <= res_page_q;
			out_stat_q <= res_stat_q;
			out_free_q <= free_now;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {7'd0, out_free_q, out_page_q};

endmodule

// File: verif/tb_page_bitmap_allocator.sv
// Self-checking testbench for page_bitmap_allocator: directed and random requests,
// a scoreboard that predicts every result, random stalls on both streams.
// Depends on pba_pkg and the page_bitmap_allocator RTL only.
module tb_page_bitmap_allocator;
	import pba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// the one mode the package leaves unnamed; the block answers it without change
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned ITEMS_PER_PHASE = 22;
	localparam int          BITMAP_WORDS    = 2048;

	typedef struct {
		logic [PAGE_W-1:0]  page_no;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] free_pages;
	} alloc_result_t;

	// Scoreboard: own copy of the bitmap, used counter and page_count register.
	// note_request() works out the result of an accepted request, check_result()
	// compares a result transfer with the oldest one still awaited.
	class page_alloc_scoreboard;
		bit                 used_map [MAX_PAGES];
		logic [COUNT_W-1:0] used_pages;
		logic [COUNT_W-1:0] page_count;
		alloc_result_t      awaited [$];
		int                 errors;

		function new();
			used_pages = '0;
			page_count = '0;
			errors     = 0;
		endfunction

		function void set_page_count(logic [COUNT_W-1:0] value);
			page_count = value;
		endfunction

		// usable pages: register value capped at the bitmap capacity and at MAX_PAGES
		function int unsigned limit();
			int unsigned lim;
			lim = page_count;
			if (lim > BITMAP_WORDS * WORD_W)
				lim = BITMAP_WORDS * WORD_W;
			if (lim > MAX_PAGES)
				lim = MAX_PAGES;
			return lim;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] idx);
			int unsigned   lim;
			int unsigned   i;
			alloc_result_t r;
			lim       = limit();
			r.page_no = '0;
			r.status  = STAT_OK;
			case (mode)
				MODE_ALLOC: begin
					// lowest free page from 1 up; page 0 is never handed out
					r.status = STAT_NO_FREE;
					for (i = 1; i < lim && r.status == STAT_NO_FREE; i++) begin
						if (!used_map[i]) begin
							used_map[i] = 1'b1;
							used_pages  = used_pages + 1'b1;
							r.page_no   = i[PAGE_W-1:0];
							r.status    = STAT_OK;
						end
					end
				end
				MODE_MARK_USED, MODE_MARK_FREE: begin
					if (idx >= lim) begin
						r.status = STAT_BAD_PAGE;
					end else if (mode == MODE_MARK_USED) begin
						if (!used_map[idx]) begin
							used_map[idx] = 1'b1;
							used_pages    = used_pages + 1'b1;
						end
					end else if (used_map[idx]) begin
						used_map[idx] = 1'b0;
						used_pages    = used_pages - 1'b1;
					end
				end
				default: begin
				end
			endcase
			// stale bits above a shrunk limit keep counting, so this saturates
			r.free_pages = (used_pages < lim) ? COUNT_W'(lim - used_pages) : '0;
			awaited.push_back(r);
		endfunction

		function void check_result(logic [STAT_W-1:0] status, logic [PAGE_W-1:0] page_no,
				logic [COUNT_W-1:0] free_pages);
			alloc_result_t exp_r;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result page %0d status %0d free %0d",
					$time, page_no, status, free_pages);
				return;
			end
			exp_r = awaited.pop_front();
			if (page_no !== exp_r.page_no || status !== exp_r.status
					|| free_pages !== exp_r.free_pages) begin
				errors++;
				$display("%0t: mismatch expected page %0d status %0d free %0d, got page %0d status %0d free %0d",
					$time, exp_r.page_no, exp_r.status, exp_r.free_pages,
					page_no, status, free_pages);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;      // mode[1:0]
	logic [15:0] s_tdata;      // page_index[15:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [1:0]  m_tuser;      // status[1:0]
	logic [39:0] m_tdata;      // result_page[15:0], free_count[32:16], zero pad [39:33]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [16:0] cfg_data;     // page_count

	page_alloc_scoreboard sb;
	bit                   hold_off_req;

	page_bitmap_allocator #(
		.BITMAP_WORDS(BITMAP_WORDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Generous cap: clearing pass plus every request as a full-length scan
	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	// Result side: sample every completed transfer at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[15:0], m_tdata[32:16]);
	end

	// Receiver back-pressure: stretches of always-ready, coin-toss and mostly-stalled,
	// plus one long hold-off on request to fill the block and stall its input.
	initial begin : receiver
		int unsigned pattern;
		int unsigned stretch;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				pattern = $urandom_range(0, 2);
				stretch = $urandom_range(10, 60);
				repeat (stretch) begin
					case (pattern)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						default: m_tready <= ($urandom_range(0, 4) == 0);
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// Offer one request from a falling edge and hold it until the transfer;
	// returns at the following falling edge with s_tvalid still high.
	task automatic offer_request(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] idx);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= idx;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(mode, idx);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// page_count write, only with nothing in flight
	task automatic write_page_count(logic [COUNT_W-1:0] value);
		s_tvalid <= 1'b0;
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_page_count(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random request shaped around the current limit: mostly allocations and marks
	// on live pages, some at the edge of the range, some anywhere, a few unused mode.
	task automatic pick_request(output logic [MODE_W-1:0] mode, output logic [PAGE_W-1:0] idx);
		int unsigned lim;
		int unsigned roll;
		int unsigned pos;
		lim  = sb.limit();
		roll = $urandom_range(0, 99);
		idx  = PAGE_W'($urandom());
		if (roll < 45)
			mode = MODE_ALLOC;
		else if (roll < 65)
			mode = MODE_MARK_USED;
		else if (roll < 93)
			mode = MODE_MARK_FREE;
		else
			mode = MODE_UNUSED;
		if (mode == MODE_MARK_USED || mode == MODE_MARK_FREE) begin
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				if (lim == 0)
					pos = $urandom_range(0, 3);
				else
					pos = $urandom_range(0, (lim < 128) ? lim - 1 : 127);
				idx = PAGE_W'(pos);
			end else if (roll < 9) begin
				// just at or past the limit
				pos = lim + $urandom_range(0, 2);
				idx = (pos > 16'hFFFF) ? 16'hFFFF - PAGE_W'($urandom_range(0, 2)) : PAGE_W'(pos);
			end
		end
	endtask

	initial begin : stimulus
		logic [COUNT_W-1:0] phase_counts [12];
		logic [MODE_W-1:0]  mode;
		logic [PAGE_W-1:0]  idx;
		int unsigned        sent;
		int unsigned        burst;
		int unsigned        gap;
		int unsigned        phase_items;

		sb           = new();
		hold_off_req = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tuser      = '0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no pages at all: allocate fails, marks are out of range, the unused mode changes nothing
		write_page_count(17'd0);
		offer_request(MODE_ALLOC, 16'h0000);
		offer_request(MODE_MARK_USED, 16'h0000);
		offer_request(MODE_MARK_FREE, 16'hFFFF);
		offer_request(MODE_UNUSED, 16'hFFFF);

		// one page, page 0 only: allocate cannot succeed, marks on page 0 repeat
		write_page_count(17'd1);
		offer_request(MODE_ALLOC, 16'hFFFF);
		offer_request(MODE_MARK_USED, 16'h0000);
		offer_request(MODE_MARK_USED, 16'h0000);
		offer_request(MODE_MARK_FREE, 16'h0000);
		offer_request(MODE_MARK_FREE, 16'h0000);

		// full capacity: top page, lowest-free allocation, refill of a hole
		write_page_count(17'h10000);
		offer_request(MODE_MARK_USED, 16'hFFFF);
		offer_request(MODE_MARK_FREE, 16'hFFFF);
		offer_request(MODE_MARK_USED, 16'h8000);
		offer_request(MODE_ALLOC, 16'h0000);
		offer_request(MODE_ALLOC, 16'h0000);
		offer_request(MODE_ALLOC, 16'h0000);
		offer_request(MODE_MARK_FREE, 16'h0002);
		offer_request(MODE_ALLOC, 16'h0000);
		offer_request(MODE_MARK_FREE, 16'h5555);

		// register above capacity acts as capacity
		write_page_count(17'h1FFFF);
		offer_request(MODE_ALLOC, 16'h0000);
		offer_request(MODE_MARK_FREE, 16'h8000);

		// shrink below the used pages: free count saturates, allocate fails
		write_page_count(17'd4);
		offer_request(MODE_ALLOC, 16'h0000);
		offer_request(MODE_MARK_USED, 16'h0004);
		offer_request(MODE_UNUSED, 16'h0000);

		phase_counts = '{17'd40, 17'd64, 17'd7, 17'd200, 17'd33, 17'h10000, 17'd1,
			17'd100, 17'h1FFFF, 17'd0, 17'd2, 17'd96};
		phase_counts[9] = COUNT_W'($urandom_range(0, 300));

		for (int p = 0; p < 12; p++) begin
			write_page_count(p == 11 ? COUNT_W'($urandom()) : phase_counts[p]);
			phase_items = ITEMS_PER_PHASE;
			if (p == 3) begin
				// long receiver hold-off while requests keep coming
				hold_off_req = 1'b1;
				phase_items  = 30;
			end
			sent = 0;
			while (sent < phase_items) begin
				burst = $urandom_range(1, 10);
				while (burst != 0 && sent < phase_items) begin
					pick_request(mode, idx);
					offer_request(mode, idx);
					sent++;
					burst--;
					if (p == 5 && sent == 12) begin
						// sender pause until the block has answered everything
						s_tvalid <= 1'b0;
						wait_results_drained();
					end
				end
				gap = $urandom_range(0, 8);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end

		s_tvalid <= 1'b0;
		wait_results_drained();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
